### design/psbb_pkg.sv
// Shared types and constants for the posed shape bounding box core.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package psbb_pkg;

   localparam logic [2:0] OP_POSE   = 3'd0;
   localparam logic [2:0] OP_SPHERE = 3'd1;
   localparam logic [2:0] OP_BOX    = 3'd2;
   localparam logic [2:0] OP_CAPSULE = 3'd3;
   localparam logic [2:0] OP_VERTEX = 3'd4;

   localparam logic [15:0] MARGIN_RESET = 16'd655;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QMUL,
      ST_MTX,
      ST_ROT_VEC,
      ST_ROT_ARG,
      ST_ROT_CAP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load;
      logic       load_pose;
      logic       qmul;
      logic [3:0] qidx;
      logic       mtx;
      logic       mul;
      logic       use_arg;
      logic [1:0] row;
      logic [1:0] col;
      logic       to_ext;
      logic       abs_res;
      logic       cap;
      logic       finish;
      logic       fin_vertex;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_sts_type;

endpackage

### design/psbb_ctrl.sv
// Sequencing state machine for the posed shape bounding box core.
// Depends on psbb_pkg; drives the datapath through dp_cmd_type.
`timescale 1ns / 1ps
module psbb_ctrl import psbb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic       req_last,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       last_ff, last_in;
   logic [1:0] row_ff, row_in, col_ff, col_in;
   logic [3:0] qidx_ff, qidx_in;
   logic       grid_end;

   assign grid_end = (row_ff == 2'd2) && (col_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_POSE;
         last_ff  <= 1'b0;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
         qidx_ff  <= 4'd0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         last_ff  <= last_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         qidx_ff  <= qidx_in;
      end
   end

   // next state and step counters
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      last_in  = last_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      qidx_in  = qidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_operation;
               last_in = req_last;
               row_in  = 2'd0;
               col_in  = 2'd0;
               qidx_in = 4'd0;
               if (req_operation == OP_POSE) begin
                  state_in = ST_QMUL;
               end else if (req_operation == OP_SPHERE || req_operation == OP_BOX ||
                            req_operation == OP_CAPSULE || req_operation == OP_VERTEX) begin
                  state_in = ST_ROT_VEC;
               end
            end
         end
         ST_QMUL: begin
            qidx_in = qidx_ff + 4'd1;
            if (qidx_ff == 4'd8) begin
               state_in = ST_MTX;
            end
         end
         ST_MTX: state_in = ST_IDLE;
         ST_ROT_VEC, ST_ROT_ARG: begin
            if (col_ff == 2'd2) begin
               col_in = 2'd0;
               row_in = row_ff + 2'd1;
            end else begin
               col_in = col_ff + 2'd1;
            end
            if (grid_end) begin
               row_in = 2'd0;
               col_in = 2'd0;
               if (state_ff == ST_ROT_ARG || op_ff == OP_SPHERE) begin
                  state_in = ST_DRAIN;
               end else if (op_ff == OP_CAPSULE) begin
                  state_in = ST_ROT_CAP;
                  col_in   = 2'd1;
               end else begin
                  state_in = ST_ROT_ARG;
               end
            end
         end
         ST_ROT_CAP: begin
            row_in = row_ff + 2'd1;
            if (row_ff == 2'd2) begin
               row_in   = 2'd0;
               col_in   = 2'd0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      cmd            = '0;
      cmd.qidx       = qidx_ff;
      cmd.row        = row_ff;
      cmd.col        = col_ff;
      cmd.abs_res    = (op_ff == OP_BOX);
      cmd.fin_vertex = (op_ff == OP_VERTEX);
      cmd.emit       = (op_ff != OP_VERTEX) || last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_pose = req_valid && (req_operation == OP_POSE);
            cmd.load      = req_valid && (req_operation == OP_SPHERE ||
                            req_operation == OP_BOX || req_operation == OP_CAPSULE ||
                            req_operation == OP_VERTEX);
         end
         ST_QMUL:    cmd.qmul = 1'b1;
         ST_MTX:     cmd.mtx = 1'b1;
         ST_ROT_VEC: cmd.mul = 1'b1;
         ST_ROT_ARG: begin
            cmd.mul     = 1'b1;
            cmd.use_arg = 1'b1;
            cmd.to_ext  = (op_ff == OP_BOX);
         end
         ST_ROT_CAP: begin
            cmd.mul     = 1'b1;
            cmd.use_arg = 1'b1;
            cmd.to_ext  = 1'b1;
            cmd.cap     = 1'b1;
         end
         ST_DRAIN: ;
         ST_FINISH:  cmd.finish = !sts.out_busy;
         default: ;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.out_busy) else $error("finish while result held");
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mul && cmd.qmul)) else $error("both multipliers commanded");
   a_shape_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_ROT_VEC) else $error("shape did not start rotation");
   a_pose_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load_pose |=> state_ff == ST_QMUL) else $error("pose did not start matrix");
`endif

endmodule

### design/psbb_dp.sv
// Datapath: pose and matrix store, shared rotation multiplier, accumulators,
// running hull box and result register. Depends on psbb_pkg.
`timescale 1ns / 1ps
module psbb_dp import psbb_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int QUAT_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   output dp_sts_type                    sts,
   input  logic [2:0]                    req_operation,
   input  logic signed [COORD_WIDTH-1:0] req_vec_x,
   input  logic signed [COORD_WIDTH-1:0] req_vec_y,
   input  logic signed [COORD_WIDTH-1:0] req_vec_z,
   input  logic signed [QUAT_WIDTH-1:0]  req_rot_w,
   input  logic signed [QUAT_WIDTH-1:0]  req_rot_x,
   input  logic signed [QUAT_WIDTH-1:0]  req_rot_y,
   input  logic signed [QUAT_WIDTH-1:0]  req_rot_z,
   input  logic signed [COORD_WIDTH-1:0] req_arg_a,
   input  logic signed [COORD_WIDTH-1:0] req_arg_b,
   input  logic signed [COORD_WIDTH-1:0] req_arg_c,
   input  logic                          csr_wr_en,
   input  logic [15:0]                   csr_wr_data,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_lo [3],
   output logic signed [COORD_WIDTH-1:0] rsp_hi [3]
);

   localparam int CW  = COORD_WIDTH;
   localparam int QW  = QUAT_WIDTH;
   localparam int F   = QW - 2;
   localparam int MW  = F + 3;
   localparam int PRW = MW + CW - F;
   localparam int AW  = CW + 4;
   localparam int PW  = 2 * QW;
   localparam int EW  = PW + 3;

   localparam logic signed [EW-1:0]    ONE_E  = EW'(1) << (2 * F);
   localparam logic signed [EW-1:0]    HALF_E = EW'(1) << (F - 1);
   localparam logic signed [EW-F-1:0]  LIM_V  = (EW-F)'(2) << F;
   localparam logic signed [EW-F-1:0]  NLIM_V = -LIM_V;
   localparam logic signed [MW-1:0]    IDENT  = MW'(1) << F;
   localparam logic signed [MW+CW-1:0] HALF_P = (MW+CW)'(1) << (F - 1);
   localparam logic signed [AW-1:0]    CMAX_A = {{5{1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [AW-1:0]    CMIN_A = {{5{1'b1}}, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0]    CMAX   = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0]    CMIN   = {1'b1, {(CW-1){1'b0}}};

   function automatic logic signed [MW-1:0] rnd_ent(input logic signed [EW-1:0] e);
      logic signed [EW-1:0]   s;
      logic signed [EW-F-1:0] v;
      s = e + HALF_E;
      v = s[EW-1:F];
      if (v > LIM_V)       return LIM_V[MW-1:0];
      else if (v < NLIM_V) return NLIM_V[MW-1:0];
      else                 return v[MW-1:0];
   endfunction

   function automatic logic signed [CW-1:0] sat_c(input logic signed [AW-1:0] v);
      if (v > CMAX_A)      return CMAX;
      else if (v < CMIN_A) return CMIN;
      else                 return v[CW-1:0];
   endfunction

   function automatic logic signed [EW-1:0] xq(input logic signed [PW-1:0] p);
      return {{3{p[PW-1]}}, p};
   endfunction

   function automatic logic signed [AW-1:0] xc(input logic signed [CW-1:0] c);
      return {{4{c[CW-1]}}, c};
   endfunction

   logic [15:0]            margin_ff;
   logic signed [CW-1:0]   pos_ff [3];
   logic signed [QW-1:0]   quat_ff [4];
   logic signed [PW-1:0]   qp_ff [9];
   logic signed [MW-1:0]   mtx_ff [3][3];
   logic signed [MW-1:0]   ent [3][3];
   logic signed [CW-1:0]   vec_ff [3];
   logic signed [CW-1:0]   arg_ff [3];
   logic signed [AW-1:0]   ctr_ff [3];
   logic signed [AW-1:0]   ext_ff [3];
   logic signed [CW-1:0]   hlo_ff [3];
   logic signed [CW-1:0]   hhi_ff [3];
   logic signed [PRW-1:0]  prod_ff;
   logic                   pv_ff;
   logic                   pext_ff;
   logic                   pabs_ff;
   logic [1:0]             prow_ff;
   logic                   rsp_valid_ff;
   logic signed [CW-1:0]   lo_ff [3];
   logic signed [CW-1:0]   hi_ff [3];

   logic signed [QW-1:0]   qa, qb;
   logic signed [PW-1:0]   qprod;
   logic signed [MW-1:0]   a_sel;
   logic signed [CW-1:0]   b_sel;
   logic signed [MW+CW-1:0] full;
   logic signed [MW+CW-1:0] full_r;
   logic signed [AW-1:0]   pacc;
   logic signed [CW-1:0]   q [3];
   logic signed [CW-1:0]   nlo [3];
   logic signed [CW-1:0]   nhi [3];
   logic signed [AW-1:0]   margin_a;
   logic signed [CW-1:0]   lo_in [3];
   logic signed [CW-1:0]   hi_in [3];

   assign sts.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_lo       = lo_ff;
   assign rsp_hi       = hi_ff;

   // quaternion products: xx yy zz xy xz yz wx wy wz
   always_comb begin
      qa = quat_ff[1];
      qb = quat_ff[1];
      unique case (cmd.qidx)
         4'd0: begin qa = quat_ff[1]; qb = quat_ff[1]; end
         4'd1: begin qa = quat_ff[2]; qb = quat_ff[2]; end
         4'd2: begin qa = quat_ff[3]; qb = quat_ff[3]; end
         4'd3: begin qa = quat_ff[1]; qb = quat_ff[2]; end
         4'd4: begin qa = quat_ff[1]; qb = quat_ff[3]; end
         4'd5: begin qa = quat_ff[2]; qb = quat_ff[3]; end
         4'd6: begin qa = quat_ff[0]; qb = quat_ff[1]; end
         4'd7: begin qa = quat_ff[0]; qb = quat_ff[2]; end
         4'd8: begin qa = quat_ff[0]; qb = quat_ff[3]; end
         default: begin qa = quat_ff[0]; qb = quat_ff[0]; end
      endcase
      qprod = qa * qb;
   end

   always_comb begin
      ent[0][0] = rnd_ent(ONE_E - ((xq(qp_ff[1]) + xq(qp_ff[2])) <<< 1));
      ent[0][1] = rnd_ent((xq(qp_ff[3]) - xq(qp_ff[8])) <<< 1);
      ent[0][2] = rnd_ent((xq(qp_ff[4]) + xq(qp_ff[7])) <<< 1);
      ent[1][0] = rnd_ent((xq(qp_ff[3]) + xq(qp_ff[8])) <<< 1);
      ent[1][1] = rnd_ent(ONE_E - ((xq(qp_ff[0]) + xq(qp_ff[2])) <<< 1));
      ent[1][2] = rnd_ent((xq(qp_ff[5]) - xq(qp_ff[6])) <<< 1);
      ent[2][0] = rnd_ent((xq(qp_ff[4]) - xq(qp_ff[7])) <<< 1);
      ent[2][1] = rnd_ent((xq(qp_ff[5]) + xq(qp_ff[6])) <<< 1);
      ent[2][2] = rnd_ent(ONE_E - ((xq(qp_ff[0]) + xq(qp_ff[1])) <<< 1));
   end

   // rotation product, matrix fraction bits rounded off to the coordinate scale
   always_comb begin
      a_sel = mtx_ff[cmd.row][cmd.col];
      if (cmd.cap && a_sel[MW-1]) a_sel = -a_sel;
      b_sel  = cmd.use_arg ? arg_ff[cmd.col] : vec_ff[cmd.col];
      full   = a_sel * b_sel;
      full_r = full + HALF_P;
      pacc   = {prod_ff[PRW-1], prod_ff};
      if (pabs_ff && pacc[AW-1]) pacc = -pacc;
   end

   // final box, both for shapes and for the hull
   always_comb begin
      margin_a = AW'(margin_ff);
      for (int i = 0; i < 3; i++) begin
         q[i]   = sat_c(ctr_ff[i]);
         nlo[i] = (q[i] < hlo_ff[i]) ? q[i] : hlo_ff[i];
         nhi[i] = (q[i] > hhi_ff[i]) ? q[i] : hhi_ff[i];
         if (cmd.fin_vertex) begin
            lo_in[i] = sat_c(xc(nlo[i]) - margin_a);
            hi_in[i] = sat_c(xc(nhi[i]) + margin_a);
         end else begin
            lo_in[i] = sat_c(ctr_ff[i] - ext_ff[i]);
            hi_in[i] = sat_c(ctr_ff[i] + ext_ff[i]);
         end
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff    <= MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            hlo_ff[i] <= CMAX;
            hhi_ff[i] <= CMIN;
            for (int j = 0; j < 3; j++) begin
               mtx_ff[i][j] <= (i == j) ? IDENT : '0;
            end
         end
      end else begin
         if (csr_wr_en) margin_ff <= csr_wr_data;
         pv_ff <= cmd.mul;
         if (cmd.finish && cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load_pose) begin
            pos_ff[0] <= req_vec_x;
            pos_ff[1] <= req_vec_y;
            pos_ff[2] <= req_vec_z;
         end
         if (cmd.mtx) mtx_ff <= ent;
         if (cmd.finish && cmd.fin_vertex) begin
            for (int i = 0; i < 3; i++) begin
               hlo_ff[i] <= cmd.emit ? CMAX : nlo[i];
               hhi_ff[i] <= cmd.emit ? CMIN : nhi[i];
            end
         end
      end
   end

   // payload flops
   always_ff @(posedge clock) begin
      if (cmd.load_pose) begin
         quat_ff[0] <= req_rot_w;
         quat_ff[1] <= req_rot_x;
         quat_ff[2] <= req_rot_y;
         quat_ff[3] <= req_rot_z;
      end
      if (cmd.qmul) qp_ff[cmd.qidx] <= qprod;
      if (cmd.mul) begin
         prod_ff <= full_r[MW+CW-1:F];
         pext_ff <= cmd.to_ext;
         // only the box extent sums magnitudes; the center stays signed
         pabs_ff <= cmd.abs_res && cmd.to_ext && !cmd.cap;
         prow_ff <= cmd.row;
      end
      if (cmd.load) begin
         vec_ff[0] <= req_vec_x;
         vec_ff[1] <= req_vec_y;
         vec_ff[2] <= req_vec_z;
         arg_ff[0] <= req_arg_a;
         arg_ff[1] <= req_arg_b;
         arg_ff[2] <= req_arg_c;
         for (int i = 0; i < 3; i++) begin
            ctr_ff[i] <= xc(pos_ff[i]);
            ext_ff[i] <= (req_operation == OP_SPHERE || req_operation == OP_CAPSULE) ?
                         xc(req_arg_a) : '0;
         end
      end else if (pv_ff) begin
         if (pext_ff) ext_ff[prow_ff] <= ext_ff[prow_ff] + pacc;
         else         ctr_ff[prow_ff] <= ctr_ff[prow_ff] + pacc;
      end
      if (cmd.finish && cmd.emit) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(lo_ff[0]) && $stable(hi_ff[2]))
      else $error("held result changed");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.finish) else $error("result overrun");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !pv_ff) else $error("finish with product in flight");
`endif

endmodule

### design/posed_shape_bounding_box_core.sv
// Pose requests form 9 quaternion products, then the matrix; shapes rotate the
// center vector, and capsule, box and hull vertex also rotate an argument.
// Throughput: one request at a time; the single coordinate-by-matrix multiplier
// takes one product per cycle. A finished result waits in the output register
// while the next request is accepted. Synchronous active-high reset restores
// identity pose, margin 655 and an empty hull box.
`timescale 1ns / 1ps
// Top level of the posed shape bounding box core.
// Depends on psbb_pkg, psbb_ctrl and psbb_dp.
module posed_shape_bounding_box_core import psbb_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int QUAT_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_operation,
   input  logic signed [COORD_WIDTH-1:0] req_vec_x,
   input  logic signed [COORD_WIDTH-1:0] req_vec_y,
   input  logic signed [COORD_WIDTH-1:0] req_vec_z,
   input  logic signed [QUAT_WIDTH-1:0]  req_rot_w,
   input  logic signed [QUAT_WIDTH-1:0]  req_rot_x,
   input  logic signed [QUAT_WIDTH-1:0]  req_rot_y,
   input  logic signed [QUAT_WIDTH-1:0]  req_rot_z,
   input  logic signed [COORD_WIDTH-1:0] req_arg_a,
   input  logic signed [COORD_WIDTH-1:0] req_arg_b,
   input  logic signed [COORD_WIDTH-1:0] req_arg_c,
   input  logic                          req_last,
   input  logic                          csr_wr_en,
   input  logic [15:0]                   csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_min_x,
   output logic signed [COORD_WIDTH-1:0] rsp_min_y,
   output logic signed [COORD_WIDTH-1:0] rsp_min_z,
   output logic signed [COORD_WIDTH-1:0] rsp_max_x,
   output logic signed [COORD_WIDTH-1:0] rsp_max_y,
   output logic signed [COORD_WIDTH-1:0] rsp_max_z
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic signed [COORD_WIDTH-1:0] lo [3];
   logic signed [COORD_WIDTH-1:0] hi [3];

   // sequencing: accept, quaternion products, rotation steps, finish
   psbb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_last      (req_last),
      .sts           (sts),
      .cmd           (cmd)
   );

   // arithmetic, pose and hull state, result register
   psbb_dp #(
      .COORD_WIDTH (COORD_WIDTH),
      .QUAT_WIDTH  (QUAT_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_operation (req_operation),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .req_rot_w     (req_rot_w),
      .req_rot_x     (req_rot_x),
      .req_rot_y     (req_rot_y),
      .req_rot_z     (req_rot_z),
      .req_arg_a     (req_arg_a),
      .req_arg_b     (req_arg_b),
      .req_arg_c     (req_arg_c),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_lo        (lo),
      .rsp_hi        (hi)
   );

   // unpack the box corners onto the result ports
   assign rsp_min_x = lo[0];
   assign rsp_min_y = lo[1];
   assign rsp_min_z = lo[2];
   assign rsp_max_x = hi[0];
   assign rsp_max_y = hi[1];
   assign rsp_max_z = hi[2];

endmodule
